### rtl/core/vmf_pkg.sv
// vmf_pkg: shared constants and types for the volume morphology filter.
// No dependencies.
`default_nettype none
package vmf_pkg;
  localparam int MaxDim    = 64;
  localparam int MaxExt    = 2;
  localparam int VoxelBits = 16;
  localparam int MaxDepth  = 4096;

  localparam logic [2:0] RegOpMode = 3'd0;
  localparam logic [2:0] RegShape  = 3'd1;
  localparam logic [2:0] RegExtX   = 3'd2;
  localparam logic [2:0] RegExtY   = 3'd3;
  localparam logic [2:0] RegExtZ   = 3'd4;
  localparam logic [2:0] RegWidth  = 3'd5;
  localparam logic [2:0] RegHeight = 3'd6;
  localparam logic [2:0] RegDepth  = 3'd7;

  localparam logic CmdPush  = 1'b0;
  localparam logic CmdDrain = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_READ,
    ST_WAIT,
    ST_ACC,
    ST_OUT
  } state_e;

  // item handshake sequencing at the top level
  typedef enum logic [1:0] {
    T_IDLE,
    T_CHECK,
    T_BUSY,
    T_HOLD
  } top_state_e;

  // controller -> datapath
  typedef struct packed {
    logic init;   // load window start, reset first-hit flag
    logic issue;  // read current window position
    logic acc;    // fold read data into accumulator
    logic step;   // advance window position
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pos_ok;   // current position lies inside window shape
    logic pos_last; // current position is the final one
  } dp_sts_t;
endpackage
`default_nettype wire

### rtl/core/vmf_if.sv
// vmf_if: valid/ready channel carrying one item of generic payload.
// Depends on nothing.
`default_nettype none
interface vmf_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/vmf_ram.sv
// vmf_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module vmf_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/core/vmf_ctrl.sv
// vmf_ctrl: sequencer walking the window of one output voxel.
// Depends on vmf_pkg.
`default_nettype none
module vmf_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire vmf_pkg::dp_sts_t sts_i,
  output      vmf_pkg::dp_cmd_t cmd_o,
  output      logic             busy_o,
  output      logic             done_o
);
  vmf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= vmf_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      vmf_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.init = 1'b1;
          state_d    = vmf_pkg::ST_INIT;
        end
      end
      vmf_pkg::ST_INIT: state_d = vmf_pkg::ST_READ;
      vmf_pkg::ST_READ: begin
        if (sts_i.pos_ok) begin
          cmd_o.issue = 1'b1;
          state_d     = vmf_pkg::ST_WAIT;
        end else if (sts_i.pos_last) begin
          state_d = vmf_pkg::ST_OUT;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      vmf_pkg::ST_WAIT: state_d = vmf_pkg::ST_ACC;
      vmf_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (sts_i.pos_last) begin
          state_d = vmf_pkg::ST_OUT;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = vmf_pkg::ST_READ;
        end
      end
      vmf_pkg::ST_OUT: begin
        done_o  = 1'b1;
        state_d = vmf_pkg::ST_IDLE;
      end
      default: state_d = vmf_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### rtl/core/vmf_dp.sv
// vmf_dp: counters, slice ring, window address generation and max/min unit.
// Depends on vmf_pkg and vmf_ram.
`default_nettype none
module vmf_dp #(
  parameter int MaxDim    = vmf_pkg::MaxDim,
  parameter int MaxExt    = vmf_pkg::MaxExt,
  parameter int VoxelBits = vmf_pkg::VoxelBits
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_idx_i,
  input  wire logic [12:0]          cfg_data_i,
  input  wire logic                 push_i,
  input  wire logic [VoxelBits-1:0] voxel_i,
  input  wire vmf_pkg::dp_cmd_t     cmd_i,
  input  wire logic                 done_i,
  output      vmf_pkg::dp_sts_t     sts_o,
  output      logic                 ready_o,
  output      logic [VoxelBits-1:0] value_o,
  output      logic                 last_o
);
  localparam int Slices = 2 * MaxExt + 2;
  localparam int DimW   = $clog2(MaxDim);
  localparam int SlW    = $clog2(Slices);
  localparam int ZW     = 13;
  localparam int AddrW  = $clog2(Slices * MaxDim * MaxDim);
  localparam int EW     = $clog2(2 * MaxExt + 1) + 1;  // signed offset width

  logic       op_q, shape_q;
  logic [1:0] ex_raw_q, ey_raw_q, ez_raw_q;
  logic [6:0] w_raw_q, h_raw_q;
  logic [12:0] d_raw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= 1'b0; shape_q <= 1'b0;
      ex_raw_q <= 2'd1; ey_raw_q <= 2'd1; ez_raw_q <= 2'd1;
      w_raw_q <= 7'd64; h_raw_q <= 7'd64; d_raw_q <= 13'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vmf_pkg::RegOpMode: op_q     <= cfg_data_i[0];
        vmf_pkg::RegShape:  shape_q  <= cfg_data_i[0];
        vmf_pkg::RegExtX:   ex_raw_q <= cfg_data_i[1:0];
        vmf_pkg::RegExtY:   ey_raw_q <= cfg_data_i[1:0];
        vmf_pkg::RegExtZ:   ez_raw_q <= cfg_data_i[1:0];
        vmf_pkg::RegWidth:  w_raw_q  <= cfg_data_i[6:0];
        vmf_pkg::RegHeight: h_raw_q  <= cfg_data_i[6:0];
        vmf_pkg::RegDepth:  d_raw_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective config
  logic [3:0] ex, ey, ez;
  logic [DimW:0] wv, hv;
  logic [ZW-1:0] dv;
  assign ex = (4'(ex_raw_q) > 4'(MaxExt)) ? 4'(MaxExt) : 4'(ex_raw_q);
  assign ey = (4'(ey_raw_q) > 4'(MaxExt)) ? 4'(MaxExt) : 4'(ey_raw_q);
  assign ez = (4'(ez_raw_q) > 4'(MaxExt)) ? 4'(MaxExt) : 4'(ez_raw_q);
  always_comb begin
    if (w_raw_q == '0) wv = (DimW+1)'(1);
    else if (32'(w_raw_q) > MaxDim) wv = (DimW+1)'(MaxDim);
    else wv = (DimW+1)'(w_raw_q);
    if (h_raw_q == '0) hv = (DimW+1)'(1);
    else if (32'(h_raw_q) > MaxDim) hv = (DimW+1)'(MaxDim);
    else hv = (DimW+1)'(h_raw_q);
    dv = (d_raw_q == '0) ? ZW'(1) : ((d_raw_q > 13'd4096) ? 13'd4096 : d_raw_q);
  end

  // receive / emit positions as coordinates
  logic [DimW:0] rx_q, ry_q, ox_q, oy_q;
  logic [ZW:0]   rz_q, oz_q;
  logic [SlW-1:0] rs_q, os_q;
  logic r_done, e_done;
  assign r_done = (rz_q >= (ZW+1)'(dv));
  assign e_done = (oz_q >= (ZW+1)'(dv));

  logic do_push, restart;
  logic [ZW:0] need;
  logic [ZW:0] ze;
  assign ze = e_done ? (ZW+1)'(dv) : oz_q;
  assign need = (ze > (ZW+1)'(ez)) ? ze - (ZW+1)'(ez) : '0;
  assign restart = push_i && r_done && e_done;
  always_comb begin
    do_push = 1'b0;
    if (push_i && (restart || !r_done)) begin
      if (restart) do_push = 1'b1;
      else do_push = !((rz_q >= (ZW+1)'(Slices)) &&
                       (rz_q - (ZW+1)'(Slices) >= need));
    end
  end

  logic [DimW:0] px, py;
  logic [SlW-1:0] ps;
  assign px = restart ? '0 : rx_q;
  assign py = restart ? '0 : ry_q;
  assign ps = restart ? '0 : rs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_q <= '0; ry_q <= '0; rz_q <= '0; rs_q <= '0;
      ox_q <= '0; oy_q <= '0; oz_q <= '0; os_q <= '0;
    end else if (cfg_we_i) begin
      rx_q <= '0; ry_q <= '0; rz_q <= '0; rs_q <= '0;
      ox_q <= '0; oy_q <= '0; oz_q <= '0; os_q <= '0;
    end else begin
      if (restart) begin
        ox_q <= '0; oy_q <= '0; oz_q <= '0; os_q <= '0;
      end
      if (do_push) begin
        if (px + 1'b1 < wv) begin
          rx_q <= px + 1'b1;
          ry_q <= py;
          rz_q <= restart ? '0 : rz_q;
          rs_q <= ps;
        end else begin
          rx_q <= '0;
          if (py + 1'b1 < hv) begin
            ry_q <= py + 1'b1;
            rz_q <= restart ? '0 : rz_q;
            rs_q <= ps;
          end else begin
            ry_q <= '0;
            rz_q <= (restart ? '0 : rz_q) + 1'b1;
            rs_q <= (ps == SlW'(Slices - 1)) ? '0 : ps + 1'b1;
          end
        end
      end else if (restart) begin
        rx_q <= '0; ry_q <= '0; rz_q <= '0; rs_q <= '0;
      end
      if (done_i) begin
        if (ox_q + 1'b1 < wv) ox_q <= ox_q + 1'b1;
        else begin
          ox_q <= '0;
          if (oy_q + 1'b1 < hv) oy_q <= oy_q + 1'b1;
          else begin
            oy_q <= '0;
            oz_q <= oz_q + 1'b1;
            os_q <= (os_q == SlW'(Slices - 1)) ? '0 : os_q + 1'b1;
          end
        end
      end
    end
  end

  // readiness: far voxel received, i.e. (fz,fy,fx) < (rz,ry,rx) lexicographically
  logic [DimW:0] fx, fy;
  logic [ZW:0]   fz;
  always_comb begin
    fx = (ox_q + (DimW+1)'(ex) > wv - 1'b1) ? wv - 1'b1 : ox_q + (DimW+1)'(ex);
    fy = (oy_q + (DimW+1)'(ey) > hv - 1'b1) ? hv - 1'b1 : oy_q + (DimW+1)'(ey);
    fz = (oz_q + (ZW+1)'(ez) > (ZW+1)'(dv) - 1'b1) ? (ZW+1)'(dv) - 1'b1
                                                   : oz_q + (ZW+1)'(ez);
  end
  assign ready_o = !e_done && ((rz_q > fz) ||
                   (rz_q == fz && (ry_q > fy || (ry_q == fy && rx_q > fx))));
  assign last_o  = (oz_q == (ZW+1)'(dv) - 1'b1) && (oy_q == hv - 1'b1) &&
                   (ox_q == wv - 1'b1);

  // window walk
  logic signed [EW-1:0] dx_q, dy_q, dz_q;
  logic signed [EW-1:0] sex, sey, sez;
  assign sex = EW'(ex); assign sey = EW'(ey); assign sez = EW'(ez);
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      dx_q <= -sex; dy_q <= -sey; dz_q <= -sez;
    end else if (cmd_i.step) begin
      if (dx_q != sex) dx_q <= dx_q + 1'b1;
      else begin
        dx_q <= -sex;
        if (dy_q != sey) dy_q <= dy_q + 1'b1;
        else begin
          dy_q <= -sey;
          dz_q <= dz_q + 1'b1;
        end
      end
    end
  end
  assign sts_o.pos_last = (dx_q == sex) && (dy_q == sey) && (dz_q == sez);

  // ellipsoid test: products of small squares (ext <= 2 per package)
  logic [7:0] qx, qy, qz, sx, sy, sz;
  logic [15:0] lim, s;
  logic [7:0] ax, ay, az;
  assign qx = 8'(ex * ex); assign qy = 8'(ey * ey); assign qz = 8'(ez * ez);
  assign sx = (qx != '0) ? qx : 8'd1;
  assign sy = (qy != '0) ? qy : 8'd1;
  assign sz = (qz != '0) ? qz : 8'd1;
  assign ax = 8'(dx_q * dx_q); assign ay = 8'(dy_q * dy_q); assign az = 8'(dz_q * dz_q);
  assign lim = 16'(sx * sy * sz);
  assign s = ((qx != '0) ? 16'(ax * sy * sz) : 16'd0) +
             ((qy != '0) ? 16'(ay * sx * sz) : 16'd0) +
             ((qz != '0) ? 16'(az * sx * sy) : 16'd0);
  assign sts_o.pos_ok = !shape_q || (s <= lim);

  // clamped neighbour address
  logic signed [DimW+2:0] nx, ny;
  logic signed [ZW+2:0]   nz;
  logic [DimW-1:0] cx, cy;
  logic [SlW-1:0]  cs;
  logic signed [SlW+1:0] sl;
  always_comb begin
    nx = $signed({2'b0, ox_q}) + (DimW+3)'(dx_q);
    ny = $signed({2'b0, oy_q}) + (DimW+3)'(dy_q);
    nz = $signed({2'b0, oz_q}) + (ZW+3)'(dz_q);
    if (nx < 0) cx = '0;
    else if (nx > $signed({2'b0, wv - 1'b1})) cx = DimW'(wv - 1'b1);
    else cx = DimW'(nx);
    if (ny < 0) cy = '0;
    else if (ny > $signed({2'b0, hv - 1'b1})) cy = DimW'(hv - 1'b1);
    else cy = DimW'(ny);
    // slice offset relative to the output slice, clamped to the volume
    if (nz < 0) sl = -$signed((SlW+2)'(oz_q));
    else if (nz > $signed({2'b0, (ZW+1)'(dv) - 1'b1}))
      sl = (SlW+2)'($signed({1'b0, (ZW+1)'(dv) - 1'b1 - oz_q}));
    else sl = (SlW+2)'(dz_q);
    sl = $signed({2'b0, os_q}) + sl;
    if (sl < 0) sl = sl + (SlW+2)'(Slices);
    else if (sl >= (SlW+2)'(Slices)) sl = sl - (SlW+2)'(Slices);
    cs = SlW'(sl);
  end

  logic [AddrW-1:0] raddr, waddr;
  assign raddr = AddrW'(cs) * AddrW'(MaxDim * MaxDim) + AddrW'(cy) * AddrW'(MaxDim) +
                 AddrW'(cx);
  assign waddr = AddrW'(ps) * AddrW'(MaxDim * MaxDim) + AddrW'(py[DimW-1:0]) * AddrW'(MaxDim) +
                 AddrW'(px[DimW-1:0]);

  logic [VoxelBits-1:0] rdata;
  vmf_ram #(.Width(VoxelBits), .Depth(Slices * MaxDim * MaxDim)) u_ring (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (waddr),
    .wdata_i (voxel_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // accumulator; centre is always inside the window so seed with first hit
  logic [VoxelBits-1:0] acc_q;
  logic first_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) first_q <= 1'b1;
    else if (cmd_i.acc) begin
      first_q <= 1'b0;
      if (first_q) acc_q <= rdata;
      else if (op_q ? (rdata < acc_q) : (rdata > acc_q)) acc_q <= rdata;
    end
  end
  assign value_o = acc_q;
endmodule
`default_nettype wire

### rtl/core/volume_morphology_filter.sv
// volume_morphology_filter: streaming 3-D grayscale dilation/erosion, top level.
// Depends on vmf_pkg, vmf_if, vmf_ctrl, vmf_dp, vmf_ram.
//
// Usage: items enter on in_if (command, voxel); command push stores a voxel
// into a ring of 2*MAX_EXT+2 slices, command drain only asks for output.
// After each accepted item the block emits on out_if the next output voxel
// (value, last) if its forward neighbours have arrived, otherwise nothing.
// One comparator walks the (2ex+1)(2ey+1)(2ez+1) window: a position outside
// the ellipsoid is only stepped over, a visited one is read, waited for and
// folded in; around the walk lie the accepting cycle, the readiness check,
// window set-up, hand-off and the output register. Input is not accepted
// while a result is computed or waits. A stalled receiver holds the result
// in the output register and blocks the input. Reset clears the counters
// and sets the config registers to their defaults; the ring is left as is
// and needs no clearing. Configuration writes restart the volume; the user
// must make them only while idle, as the block does not enforce it.
`default_nettype none
module volume_morphology_filter #(
  parameter int MaxDim    = vmf_pkg::MaxDim,
  parameter int MaxExt    = vmf_pkg::MaxExt,
  parameter int VoxelBits = vmf_pkg::VoxelBits
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_we_i,
  input wire logic [2:0]  cfg_idx_i,
  input wire logic [12:0] cfg_data_i,
  vmf_if.sink             in_if,
  vmf_if.source           out_if
);
  vmf_pkg::top_state_e t_q, t_d;

  vmf_pkg::dp_cmd_t cmd;
  vmf_pkg::dp_sts_t sts;
  logic busy, done, ready, last, push, start;
  logic [VoxelBits-1:0] value;
  logic [VoxelBits-1:0] val_q;
  logic last_q;

  assign in_if.ready = (t_q == vmf_pkg::T_IDLE);
  assign push = in_if.valid && in_if.ready && (in_if.data.command == vmf_pkg::CmdPush);
  assign start = (t_q == vmf_pkg::T_CHECK) && ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t_q <= vmf_pkg::T_IDLE;
    else         t_q <= t_d;
  end

  always_comb begin
    t_d = t_q;
    unique case (t_q)
      vmf_pkg::T_IDLE:  if (in_if.valid) t_d = vmf_pkg::T_CHECK;
      vmf_pkg::T_CHECK: t_d = ready ? vmf_pkg::T_BUSY : vmf_pkg::T_IDLE;
      vmf_pkg::T_BUSY:  if (done) t_d = vmf_pkg::T_HOLD;
      vmf_pkg::T_HOLD:  if (out_if.ready) t_d = vmf_pkg::T_IDLE;
      default: t_d = vmf_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      val_q  <= value;
      last_q <= last;
    end
  end
  assign out_if.valid      = (t_q == vmf_pkg::T_HOLD);
  assign out_if.data.value = val_q;
  assign out_if.data.last  = last_q;

  vmf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done)
  );

  vmf_dp #(.MaxDim(MaxDim), .MaxExt(MaxExt), .VoxelBits(VoxelBits)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .voxel_i    (in_if.data.voxel),
    .cmd_i      (cmd),
    .done_i     (done),
    .sts_o      (sts),
    .ready_o    (ready),
    .value_o    (value),
    .last_o     (last)
  );

  logic unused;
  assign unused = busy;
endmodule
`default_nettype wire
